// ----- rtl/core/rbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types, sizes, codes and the exp(-t) table for the RBF network block.
// ----------------------------------------------------------------------------
package rbf_pkg;

    // Sizing
    localparam int MAX_KERNELS     = 32;
    localparam int MAX_FEATURES    = 16;
    localparam int MAX_OUTPUTS     = 4;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int FIDX_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int OIDX_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int ROW_W    = $clog2(MAX_KERNELS + 1);
    localparam int OCNT_W   = $clog2(MAX_OUTPUTS + 1);
    localparam int CTR_DEPTH = MAX_KERNELS * MAX_FEATURES;
    localparam int CTR_AW   = (CTR_DEPTH > 1) ? $clog2(CTR_DEPTH) : 1;
    localparam int WT_DEPTH = (MAX_KERNELS + 1) * MAX_OUTPUTS;
    localparam int WT_AW    = $clog2(WT_DEPTH);
    localparam int ETAB_AW  = $clog2(EXP_TABLE_DEPTH);

    // Arithmetic widths
    localparam int SQ_W   = 32;
    localparam int DIST_W = SQ_W + $clog2(MAX_FEATURES);
    localparam int T_W    = DIST_W + 16;
    localparam int IDX_W  = T_W - 28;
    localparam int ETAB_W = 33;
    localparam int ACC_W  = 48;

    // Command codes
    localparam logic [1:0] CMD_CENTER  = 2'd0;
    localparam logic [1:0] CMD_WEIGHT  = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_FEATURE_COUNT = 2'd0;
    localparam logic [1:0] REG_KERNEL_COUNT  = 2'd1;
    localparam logic [1:0] REG_OUTPUT_COUNT  = 2'd2;
    localparam logic [1:0] REG_INV_WIDTH_SQ  = 2'd3;

    // exp(-1/16) in Q0.32
    localparam logic [31:0] EXP_RATIO = 32'd4034748382;

    typedef logic [ETAB_W-1:0] etab_t [EXP_TABLE_DEPTH];

    function automatic etab_t build_etab();
        etab_t       tab;
        logic [65:0] p;
        tab[0] = 33'h1_0000_0000;
        for (int k = 1; k < EXP_TABLE_DEPTH; k++)
        begin
            p      = 66'(tab[k-1]) * 66'(EXP_RATIO) + 66'h8000_0000;
            tab[k] = ETAB_W'(p >> 32);
        end
        return tab;
    endfunction

    localparam etab_t EXP_TAB = build_etab();

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         row_index;
        logic [3:0]         column_index;
        logic signed [15:0] value;
        logic               last_element;
    } rbf_in_t;

    typedef struct packed {
        logic [1:0]         output_index;
        logic signed [31:0] output_value;
        logic [15:0]        confidence;
        logic               size_error;
        logic               last_result;
    } rbf_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_ACT1,
        S_ACT2,
        S_ACT3,
        S_ACT4,
        S_MAC,
        S_OUT
    } state_t;

endpackage

// ----- rtl/core/rbf_ram.sv -----
// ----------------------------------------------------------------------------
// rbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/rbf_network_inference.sv -----
// ----------------------------------------------------------------------------
// rbf_network_inference
// Gaussian RBF network forward pass: loads centers and weights, buffers a
// sample, then computes one saturated weighted sum per output.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Load requests and
// non-final features leave busy low. The final feature of a sample runs the
// network, busy while it works through fc features, nk kernels and no outputs,
// paced by the single read port of the center memory (one feature per cycle)
// and the one shared weight multiply-accumulate (one output per cycle). Results
// then appear one per cycle on result with done high for exactly one cycle each;
// the receiver cannot stall them and must take each one as it comes. A wrong
// feature count gives one error result in the cycle after the final feature.
module rbf_network_inference (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rbf_pkg::rbf_in_t request,
    output logic            done,
    output rbf_pkg::rbf_out_t result,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    rbf_pkg::state_t state_reg, state_next;

    logic [4:0]  fc_reg;
    logic [5:0]  kc_reg;
    logic [2:0]  oc_reg;
    logic [15:0] inv_reg;
    logic [4:0]  frecv_reg, frecv_next;

    logic [rbf_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [4:0]                 issue_f_reg, issue_f_next;
    logic [rbf_pkg::OCNT_W-1:0] mo_reg, mo_next;

    logic                         rd_v_reg, rd_v_next;
    logic [rbf_pkg::SQ_W-1:0]     sq_reg, sq_next;
    logic                         sq_v_reg, sq_v_next;
    logic [rbf_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [rbf_pkg::T_W-1:0]      t_reg, t_next;
    logic [rbf_pkg::ETAB_W-1:0]   a_reg, a_next;
    logic [rbf_pkg::ETAB_W-1:0]   dab_reg, dab_next;
    logic [15:0]                  frac_reg, frac_next;
    logic                         zero_reg, zero_next;
    logic [rbf_pkg::ETAB_W+15:0]  ip_reg, ip_next;
    logic [16:0]                  act_reg, act_next;
    logic [15:0]                  max_reg, max_next;

    logic                         wrd_v_reg, wrd_v_next;
    logic [rbf_pkg::OIDX_W-1:0]   wrd_o_reg, wrd_o_next;
    logic signed [33:0]           wp_reg, wp_next;
    logic                         wp_v_reg, wp_v_next;
    logic [rbf_pkg::OIDX_W-1:0]   wp_o_reg, wp_o_next;
    logic signed [rbf_pkg::ACC_W-1:0] acc_reg [rbf_pkg::MAX_OUTPUTS];
    logic signed [rbf_pkg::ACC_W-1:0] acc_next [rbf_pkg::MAX_OUTPUTS];

    logic [rbf_pkg::WT_DEPTH-1:0] wvld_reg, wvld_next;
    logic                         wvld_q_reg;

    logic              done_reg, done_next;
    rbf_pkg::rbf_out_t result_reg, result_next;

    // Memory ports
    logic                        ctr_we, smp_we, wt_we;
    logic [rbf_pkg::CTR_AW-1:0]  ctr_waddr, ctr_raddr;
    logic [rbf_pkg::FIDX_W-1:0]  smp_waddr, smp_raddr;
    logic [rbf_pkg::WT_AW-1:0]   wt_waddr, wt_raddr;
    logic [15:0]                 ctr_q, smp_q, wt_q;

    logic                        accept;
    logic [rbf_pkg::ROW_W-1:0]   nk;
    logic [rbf_pkg::OCNT_W-1:0]  no;

    assign accept = start && (state_reg == rbf_pkg::S_IDLE);
    assign busy   = (state_reg != rbf_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Register clamps
    assign nk = (32'(kc_reg) > rbf_pkg::MAX_KERNELS) ?
                rbf_pkg::ROW_W'(rbf_pkg::MAX_KERNELS) : rbf_pkg::ROW_W'(kc_reg);
    always_comb
    begin
        if (oc_reg == 3'd0)
        begin
            no = rbf_pkg::OCNT_W'(1);
        end
        else if (32'(oc_reg) > rbf_pkg::MAX_OUTPUTS)
        begin
            no = rbf_pkg::OCNT_W'(rbf_pkg::MAX_OUTPUTS);
        end
        else
        begin
            no = rbf_pkg::OCNT_W'(oc_reg);
        end
    end

    // Memory write decode
    assign ctr_we = accept && (request.command == rbf_pkg::CMD_CENTER)
                    && (32'(request.row_index) < rbf_pkg::MAX_KERNELS)
                    && (32'(request.column_index) < rbf_pkg::MAX_FEATURES);
    assign smp_we = accept && (request.command == rbf_pkg::CMD_FEATURE)
                    && (32'(request.column_index) < rbf_pkg::MAX_FEATURES);
    assign wt_we  = accept && (request.command == rbf_pkg::CMD_WEIGHT)
                    && (32'(request.row_index) <= rbf_pkg::MAX_KERNELS)
                    && (32'(request.column_index) < rbf_pkg::MAX_OUTPUTS);

    assign ctr_waddr = rbf_pkg::CTR_AW'(32'(request.row_index) * rbf_pkg::MAX_FEATURES
                       + 32'(request.column_index));
    assign smp_waddr = rbf_pkg::FIDX_W'(request.column_index);
    assign wt_waddr  = rbf_pkg::WT_AW'(32'(request.row_index) * rbf_pkg::MAX_OUTPUTS
                       + 32'(request.column_index));

    // Read addresses: centers of kernel row-1, weights of row
    assign ctr_raddr = rbf_pkg::CTR_AW'(32'(row_reg - rbf_pkg::ROW_W'(1))
                       * rbf_pkg::MAX_FEATURES + 32'(issue_f_reg));
    assign smp_raddr = rbf_pkg::FIDX_W'(issue_f_reg);
    assign wt_raddr  = rbf_pkg::WT_AW'(32'(row_reg) * rbf_pkg::MAX_OUTPUTS
                       + 32'(mo_reg));

    rbf_ram #(.WIDTH(16), .DEPTH(rbf_pkg::CTR_DEPTH)) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (request.value),
        .raddr (ctr_raddr),
        .rdata (ctr_q)
    );

    rbf_ram #(.WIDTH(16), .DEPTH(rbf_pkg::MAX_FEATURES)) u_smp_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (request.value),
        .raddr (smp_raddr),
        .rdata (smp_q)
    );

    rbf_ram #(.WIDTH(16), .DEPTH(rbf_pkg::WT_DEPTH)) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (request.value),
        .raddr (wt_raddr),
        .rdata (wt_q)
    );

    // Sequencer and datapath
    always_comb
    begin
        logic signed [16:0]           diff;
        logic [15:0]                  mag;
        logic [rbf_pkg::IDX_W-1:0]    idx;
        logic [rbf_pkg::ETAB_AW-1:0]  ti;
        logic [rbf_pkg::ETAB_W-1:0]   ea, eb;
        logic [rbf_pkg::ETAB_W-1:0]   v;
        logic [17:0]                  r;
        logic [15:0]                  act16;
        logic signed [15:0]           w;
        logic [4:0]                   fcnt;
        logic signed [rbf_pkg::ACC_W-1:0] acc;
        logic signed [31:0]           q;

        state_next   = state_reg;
        frecv_next   = frecv_reg;
        row_next     = row_reg;
        issue_f_next = issue_f_reg;
        mo_next      = mo_reg;
        rd_v_next    = 1'b0;
        sq_v_next    = rd_v_reg;
        dist_next    = dist_reg;
        t_next       = t_reg;
        a_next       = a_reg;
        dab_next     = dab_reg;
        frac_next    = frac_reg;
        zero_next    = zero_reg;
        ip_next      = ip_reg;
        act_next     = act_reg;
        max_next     = max_reg;
        wrd_v_next   = 1'b0;
        wrd_o_next   = rbf_pkg::OIDX_W'(mo_reg);
        wp_v_next    = wrd_v_reg;
        wp_o_next    = wrd_o_reg;
        acc_next     = acc_reg;
        wvld_next    = wvld_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        // Squared difference of one feature
        diff    = 17'(smp_q) - 17'(ctr_q);
        diff    = $signed({smp_q[15], smp_q}) - $signed({ctr_q[15], ctr_q});
        mag     = diff[16] ? 16'(-diff) : diff[15:0];
        sq_next = rbf_pkg::SQ_W'(32'(mag) * 32'(mag));
        if (sq_v_reg)
        begin
            dist_next = dist_reg + rbf_pkg::DIST_W'(sq_reg);
        end

        // Weight product and accumulate
        w       = wvld_q_reg ? $signed(wt_q) : 16'sd0;
        wp_next = 34'(w) * $signed({1'b0, act_reg});
        if (wp_v_reg)
        begin
            acc_next[wp_o_reg] = acc_reg[wp_o_reg] + rbf_pkg::ACC_W'(wp_reg);
        end

        // Table lookup and interpolation terms
        idx   = t_reg[rbf_pkg::T_W-1:28];
        ti    = rbf_pkg::ETAB_AW'(idx);
        ea    = rbf_pkg::EXP_TAB[ti];
        eb    = (32'(ti) == rbf_pkg::EXP_TABLE_DEPTH - 1) ? '0 :
                rbf_pkg::EXP_TAB[rbf_pkg::ETAB_AW'(ti + rbf_pkg::ETAB_AW'(1))];
        v     = a_reg - rbf_pkg::ETAB_W'(ip_reg >> 16);
        r     = 18'((34'(v) + 34'd32768) >> 16);
        act16 = zero_reg ? 16'd0 : ((r > 18'd65535) ? 16'hFFFF : r[15:0]);

        fcnt = (frecv_reg == 5'd31) ? 5'd31 : frecv_reg + 5'd1;

        // Output saturation
        acc = acc_reg[rbf_pkg::OIDX_W'(mo_reg)];
        if (acc >= (rbf_pkg::ACC_W'(1) <<< 35))
        begin
            q = 32'sh7FFF_FFFF;
        end
        else if (acc < -(rbf_pkg::ACC_W'(1) <<< 35))
        begin
            q = 32'sh8000_0000;
        end
        else
        begin
            q = 32'(acc >>> 4);
        end

        // Weight valid bits and register writes
        if (wt_we)
        begin
            wvld_next[wt_waddr] = 1'b1;
        end

        unique case (state_reg)
            rbf_pkg::S_IDLE:
            begin
                if (accept && (request.command == rbf_pkg::CMD_FEATURE))
                begin
                    frecv_next = fcnt;
                    if (request.last_element)
                    begin
                        frecv_next = 5'd0;
                        if ((fcnt != fc_reg) || (32'(fc_reg) > rbf_pkg::MAX_FEATURES))
                        begin
                            done_next                = 1'b1;
                            result_next.output_index = 2'd0;
                            result_next.output_value = 32'sd0;
                            result_next.confidence   = 16'd0;
                            result_next.size_error   = 1'b1;
                            result_next.last_result  = 1'b1;
                        end
                        else
                        begin
                            // Bias row first, with an input of 1.0
                            row_next = '0;
                            mo_next  = '0;
                            act_next = 17'h10000;
                            max_next = 16'd0;
                            for (int o = 0; o < rbf_pkg::MAX_OUTPUTS; o++)
                            begin
                                acc_next[o] = '0;
                            end
                            state_next = rbf_pkg::S_MAC;
                        end
                    end
                end
            end

            rbf_pkg::S_DIST:
            begin
                if (issue_f_reg < fc_reg)
                begin
                    rd_v_next    = 1'b1;
                    issue_f_next = issue_f_reg + 5'd1;
                end
                else if (!rd_v_reg && !sq_v_reg)
                begin
                    state_next = rbf_pkg::S_ACT1;
                end
            end

            rbf_pkg::S_ACT1:
            begin
                t_next     = rbf_pkg::T_W'(dist_reg) * rbf_pkg::T_W'(inv_reg);
                state_next = rbf_pkg::S_ACT2;
            end

            rbf_pkg::S_ACT2:
            begin
                zero_next  = (32'(idx) >= rbf_pkg::EXP_TABLE_DEPTH);
                a_next     = ea;
                dab_next   = ea - eb;
                frac_next  = t_reg[27:12];
                state_next = rbf_pkg::S_ACT3;
            end

            rbf_pkg::S_ACT3:
            begin
                ip_next    = (rbf_pkg::ETAB_W+16)'(dab_reg) * (rbf_pkg::ETAB_W+16)'(frac_reg);
                state_next = rbf_pkg::S_ACT4;
            end

            rbf_pkg::S_ACT4:
            begin
                act_next = {1'b0, act16};
                if (act16 > max_reg)
                begin
                    max_next = act16;
                end
                mo_next    = '0;
                state_next = rbf_pkg::S_MAC;
            end

            rbf_pkg::S_MAC:
            begin
                if (mo_reg < no)
                begin
                    wrd_v_next = 1'b1;
                    mo_next    = mo_reg + rbf_pkg::OCNT_W'(1);
                end
                else if (!wrd_v_reg && !wp_v_reg)
                begin
                    mo_next = '0;
                    if (row_reg == nk)
                    begin
                        state_next = rbf_pkg::S_OUT;
                    end
                    else
                    begin
                        row_next     = row_reg + rbf_pkg::ROW_W'(1);
                        issue_f_next = 5'd0;
                        dist_next    = '0;
                        state_next   = rbf_pkg::S_DIST;
                    end
                end
            end

            rbf_pkg::S_OUT:
            begin
                done_next                = 1'b1;
                result_next.output_index = 2'(mo_reg);
                result_next.output_value = q;
                result_next.confidence   = max_reg;
                result_next.size_error   = 1'b0;
                result_next.last_result  = (mo_reg == no - rbf_pkg::OCNT_W'(1));
                if (mo_reg == no - rbf_pkg::OCNT_W'(1))
                begin
                    state_next = rbf_pkg::S_IDLE;
                end
                else
                begin
                    mo_next = mo_reg + rbf_pkg::OCNT_W'(1);
                end
            end

            default:
            begin
                state_next = rbf_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg     <= 5'd16;
            kc_reg     <= 6'd32;
            oc_reg     <= 3'd1;
            inv_reg    <= 16'd256;
            frecv_reg  <= 5'd0;
            rd_v_reg   <= 1'b0;
            sq_v_reg   <= 1'b0;
            wrd_v_reg  <= 1'b0;
            wp_v_reg   <= 1'b0;
            wvld_reg   <= '0;
            wvld_q_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rbf_pkg::REG_FEATURE_COUNT: fc_reg  <= cfg_data[4:0];
                    rbf_pkg::REG_KERNEL_COUNT:  kc_reg  <= cfg_data[5:0];
                    rbf_pkg::REG_OUTPUT_COUNT:  oc_reg  <= cfg_data[2:0];
                    rbf_pkg::REG_INV_WIDTH_SQ:  inv_reg <= cfg_data;
                    default:                    inv_reg <= inv_reg;
                endcase
            end
            frecv_reg  <= frecv_next;
            rd_v_reg   <= rd_v_next;
            sq_v_reg   <= sq_v_next;
            wrd_v_reg  <= wrd_v_next;
            wp_v_reg   <= wp_v_next;
            wvld_reg   <= wvld_next;
            wvld_q_reg <= wvld_reg[wt_raddr];
            done_reg   <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        issue_f_reg <= issue_f_next;
        mo_reg      <= mo_next;
        sq_reg      <= sq_next;
        dist_reg    <= dist_next;
        t_reg       <= t_next;
        a_reg       <= a_next;
        dab_reg     <= dab_next;
        frac_reg    <= frac_next;
        zero_reg    <= zero_next;
        ip_reg      <= ip_next;
        act_reg     <= act_next;
        max_reg     <= max_next;
        wrd_o_reg   <= wrd_o_next;
        wp_reg      <= wp_next;
        wp_o_reg    <= wp_o_next;
        acc_reg     <= acc_next;
        result_reg  <= result_next;
    end

endmodule
